>>> hw/rtl/quadrature_knob_rate_and_switch_assert.svh
// Assertion macros for the quadrature knob rate and switch block.
`ifndef QUADRATURE_KNOB_RATE_AND_SWITCH_ASSERT_SVH
`define QUADRATURE_KNOB_RATE_AND_SWITCH_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define QKRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qkrs assertion failed");

// Next-cycle implication, disabled in reset.
`define QKRS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qkrs assertion failed");

`endif

>>> hw/rtl/qkrs_pkg.sv
// Shared types, constants and the transition table of the knob decoder.
package qkrs_pkg;

  localparam int unsigned COUNT_WIDTH_DEF      = 16;
  localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;
  localparam int unsigned TIME_W               = 32;
  localparam int unsigned THR_W                = 8;
  localparam logic [7:0]  THR_RESET            = 8'd2;

  typedef enum logic [1:0] {
    REQ_AB   = 2'd0,
    REQ_SW   = 2'd1,
    REQ_TICK = 2'd2
  } req_e;

  localparam logic KIND_RATE   = 1'b0;
  localparam logic KIND_SWITCH = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } qkrs_sts_t;

  // index is {new_ab, old_ab}
  function automatic logic signed [2:0] step_delta(input logic [3:0] idx);
    logic signed [2:0] d;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  d = 3'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = -3'sd1;
      4'd3, 4'd12:              d = 3'sd2;
      4'd6, 4'd9:               d = -3'sd2;
      default:                  d = 3'sd0;
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/qkrs_mul.sv
// Bit-serial multiplier: magnitude times the tick rate, one magnitude bit per cycle.
module qkrs_mul #(
  parameter int unsigned COUNT_WIDTH      = qkrs_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned TICKS_PER_SECOND = qkrs_pkg::TICKS_PER_SECOND_DEF,
  localparam int unsigned TW = $clog2(TICKS_PER_SECOND + 1),
  localparam int unsigned PW = COUNT_WIDTH + TW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [COUNT_WIDTH-1:0]  mag_i,
  output qkrs_pkg::qkrs_sts_t     sts_o,
  output logic [PW-1:0]           prod_o
);
  import qkrs_pkg::*;

  localparam int unsigned CW = $clog2(COUNT_WIDTH);
  localparam logic [PW-1:0] TPS = PW'(TICKS_PER_SECOND);

  logic                   busy_q, done_q;
  logic [CW-1:0]          cnt_q;
  logic [COUNT_WIDTH-1:0] m_q;
  logic [PW-1:0]          p_q, p_d;

  // Horner form, most significant magnitude bit first
  assign p_d = {p_q[PW-2:0], 1'b0} + (m_q[COUNT_WIDTH-1] ? TPS : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(COUNT_WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q <= mag_i;
      p_q <= '0;
    end else if (busy_q) begin
      m_q <= {m_q[COUNT_WIDTH-2:0], 1'b0};
      p_q <= p_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign prod_o     = p_q;

endmodule

>>> hw/rtl/qkrs_div.sv
// Restoring divider, one quotient bit per cycle, with signed clamp of the rate.
module qkrs_div #(
  parameter int unsigned COUNT_WIDTH      = qkrs_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned TICKS_PER_SECOND = qkrs_pkg::TICKS_PER_SECOND_DEF,
  localparam int unsigned TW = $clog2(TICKS_PER_SECOND + 1),
  localparam int unsigned PW = COUNT_WIDTH + TW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [PW-1:0]                dividend_i,
  input  logic [qkrs_pkg::TIME_W-1:0]  divisor_i,
  input  logic                         neg_i,
  output qkrs_pkg::qkrs_sts_t          sts_o,
  output logic signed [31:0]           rate_o
);
  import qkrs_pkg::*;

  localparam int unsigned CW = $clog2(PW);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [PW-1:0]     n_q;
  logic [TIME_W-1:0] dv_q, rem_q;
  logic [31:0]       q_q;
  logic              ovf_q;
  logic [TIME_W:0]   trial, diff;
  logic              ge;
  logic              q_big;

  assign trial = {rem_q, n_q[PW-1]};
  assign diff  = trial - {1'b0, dv_q};
  assign ge    = !diff[TIME_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(PW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= dividend_i;
      dv_q  <= divisor_i;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      n_q   <= {n_q[PW-2:0], 1'b0};
      rem_q <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      q_q   <= {q_q[30:0], ge};
      ovf_q <= ovf_q | q_q[31];
    end
  end

  // quotient of 2^31 or more clamps either way
  assign q_big = ovf_q | q_q[31];

  always_comb begin
    if (neg_i) begin
      rate_o = q_big ? 32'sh8000_0000 : -$signed(q_q);
    end else begin
      rate_o = q_big ? 32'sh7FFF_FFFF : $signed(q_q);
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

>>> hw/rtl/quadrature_knob_rate_and_switch.sv
// Top level of the quadrature knob decoder with rate and switch reporting.
//
// Input channel (in_valid_i / in_stall_o) carries A/B samples, switch samples
// and microsecond ticks. A/B and switch items give no result. A tick that
// finds a sample since the previous acting tick may give a rate item, a
// switch item, or both (rate first, last_o on the final one). A switch-only
// tick gives its item in the next cycle. A rate is computed by the bit-serial
// multiplier and then the restoring divider, one bit per cycle each; a zero
// interval skips both. Input is stalled while a rate is computed, and a tick
// is stalled while a result is still held. One output register holds a
// result while out_stall_i is high; a pending switch item follows once the
// rate item is taken. cfg_we_i writes the report threshold. Reset clears
// all state; the threshold resets to 2.
module quadrature_knob_rate_and_switch #(
  parameter int unsigned COUNT_WIDTH      = qkrs_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned TICKS_PER_SECOND = qkrs_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qkrs_pkg::THR_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic                         pin_a_i,
  input  logic                         pin_b_i,
  input  logic                         switch_level_i,
  input  logic [qkrs_pkg::TIME_W-1:0]  now_us_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         result_kind_o,
  output logic signed [31:0]           steps_per_second_o,
  output logic                         is_pressed_o,
  output logic                         last_o
);
  import qkrs_pkg::*;

  localparam int unsigned W  = COUNT_WIDTH;
  localparam int unsigned PW = COUNT_WIDTH + $clog2(TICKS_PER_SECOND + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_DIV  = 3'b100
  } state_e;

  state_e            state_q;
  logic signed [W-1:0] count_q;
  logic [1:0]        prev_ab_q;
  logic [TIME_W-1:0] last_time_q, delta_q;
  logic              pend_q, pressed_q, reported_q;
  logic [THR_W-1:0]  thr_q;
  logic              sw_pend_q, sw_val_q, neg_q;
  logic              out_valid_q, out_kind_q, out_press_q, out_last_q;
  logic signed [31:0] out_rate_q;

  logic              in_acc, out_acc;
  logic              is_ab, is_sw, is_tick;
  logic [1:0]        ab;
  logic signed [2:0] dstep;
  logic [W:0]        sum;
  logic [W-1:0]      count_sat, mag;
  logic [TIME_W-1:0] delta_now;
  logic              rate_go, sw_go, mul_go;
  qkrs_sts_t         mul_sts, div_sts;
  logic [PW-1:0]     prod;
  logic signed [31:0] rate;

  assign is_ab   = req_type_i == REQ_AB;
  assign is_sw   = req_type_i == REQ_SW;
  assign is_tick = req_type_i == REQ_TICK;

  assign in_stall_o = (state_q != S_IDLE) || (is_tick && (out_valid_q || sw_pend_q));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  assign ab    = {pin_a_i, pin_b_i};
  assign dstep = step_delta({ab, prev_ab_q});
  assign sum   = {count_q[W-1], count_q} + {{(W-2){dstep[2]}}, dstep};

  always_comb begin
    if (sum[W] != sum[W-1]) begin
      count_sat = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      count_sat = sum[W-1:0];
    end
  end

  assign mag       = count_q[W-1] ? W'(0) - count_q : count_q;
  assign delta_now = now_us_i - last_time_q;
  assign rate_go   = pend_q && (mag > W'(thr_q));
  assign sw_go     = pend_q && (pressed_q != reported_q);
  assign mul_go    = in_acc && is_tick && rate_go && (delta_now != '0);

  qkrs_mul #(
    .COUNT_WIDTH      (COUNT_WIDTH),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .mag_i   (mag),
    .sts_o   (mul_sts),
    .prod_o  (prod)
  );

  qkrs_div #(
    .COUNT_WIDTH      (COUNT_WIDTH),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mul_sts.done),
    .dividend_i (prod),
    .divisor_i  (delta_q),
    .neg_i      (neg_q),
    .sts_o      (div_sts),
    .rate_o     (rate)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      prev_ab_q   <= '0;
      last_time_q <= '0;
      delta_q     <= '0;
      pend_q      <= 1'b0;
      pressed_q   <= 1'b0;
      reported_q  <= 1'b0;
      thr_q       <= THR_RESET;
      sw_pend_q   <= 1'b0;
      sw_val_q    <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_RATE;
      out_press_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_rate_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end

      if (out_acc) begin
        if (sw_pend_q && (state_q == S_IDLE)) begin
          out_kind_q  <= KIND_SWITCH;
          out_rate_q  <= '0;
          out_press_q <= sw_val_q;
          out_last_q  <= 1'b1;
          sw_pend_q   <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc && is_ab) begin
            pend_q    <= 1'b1;
            count_q   <= count_sat;
            prev_ab_q <= ab;
          end else if (in_acc && is_sw) begin
            pend_q    <= 1'b1;
            pressed_q <= !switch_level_i;
          end else if (in_acc && is_tick && pend_q) begin
            pend_q <= 1'b0;
            if (sw_go) begin
              reported_q <= pressed_q;
            end
            if (rate_go) begin
              last_time_q <= now_us_i;
              count_q     <= '0;
              sw_pend_q   <= sw_go;
              sw_val_q    <= pressed_q;
              if (delta_now == '0) begin
                out_valid_q <= 1'b1;
                out_kind_q  <= KIND_RATE;
                out_rate_q  <= count_q[W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                out_press_q <= 1'b0;
                out_last_q  <= !sw_go;
              end else begin
                delta_q <= delta_now;
                neg_q   <= count_q[W-1];
                state_q <= S_MUL;
              end
            end else if (sw_go) begin
              out_valid_q <= 1'b1;
              out_kind_q  <= KIND_SWITCH;
              out_rate_q  <= '0;
              out_press_q <= pressed_q;
              out_last_q  <= 1'b1;
            end
          end
        end
        S_MUL: begin
          if (mul_sts.done) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_RATE;
            out_rate_q  <= rate;
            out_press_q <= 1'b0;
            out_last_q  <= !sw_pend_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = out_kind_q;
  assign steps_per_second_o = out_rate_q;
  assign is_pressed_o       = out_press_q;
  assign last_o             = out_last_q;

`include "quadrature_knob_rate_and_switch_assert.svh"

  `QKRS_ASSERT_IMP(a_rate_slot_free, div_sts.done, !out_valid_q)
  `QKRS_ASSERT_IMP(a_mul_in_state, mul_sts.busy, state_q == S_MUL)
  `QKRS_ASSERT_IMP(a_div_in_state, div_sts.busy, state_q == S_DIV)
  `QKRS_ASSERT_IMP(a_sw_behind_rate, sw_pend_q && !out_valid_q,
                   (state_q == S_MUL) || (state_q == S_DIV))
  `QKRS_ASSERT_NXT(a_mul_to_div, mul_sts.done, div_sts.busy)

endmodule

>>> sim/quadrature_knob_rate_and_switch_test.sv
// Self-checking testbench for the quadrature knob rate and switch block.
module quadrature_knob_rate_and_switch_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qkrs_pkg::*;

  localparam logic [1:0]      REQ_UNUSED    = 2'd3;
  localparam longint unsigned USEC_PER_S    = 1000000;
  localparam int              SETTLE_CYCLES = 60;
  localparam int              QUIET_LIMIT   = 3000;
  localparam int              COUNT_MAX     = 32767;
  localparam int              COUNT_MIN     = -32768;

  typedef struct {
    logic               kind;
    logic signed [31:0] rate;
    logic               pressed;
    logic               last;
  } knob_result_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [THR_W-1:0]   cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type  = REQ_AB;
  logic               pin_a     = 1'b0;
  logic               pin_b     = 1'b0;
  logic               sw_level  = 1'b1;
  logic [TIME_W-1:0]  now_us    = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               result_kind;
  logic signed [31:0] rate_out;
  logic               pressed_out;
  logic               last_out;

  // predicted block state
  logic signed [15:0] knob_steps     = '0;
  logic [1:0]         knob_ab        = 2'b00;
  logic [31:0]        last_report_us = '0;
  logic               sample_seen    = 1'b0;
  logic               pressed_now    = 1'b0;
  logic               pressed_sent   = 1'b0;
  logic [7:0]         rate_threshold = THR_RESET;

  knob_result_t expected_results[$];
  knob_result_t head;

  int          errors        = 0;
  int          items_sent    = 0;
  int          quiet_cycles  = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles   = 0;
  logic [1:0]  cur_ab        = 2'b00;
  logic [31:0] now_clock     = '0;

  quadrature_knob_rate_and_switch u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .req_type_i         (req_type),
    .pin_a_i            (pin_a),
    .pin_b_i            (pin_b),
    .switch_level_i     (sw_level),
    .now_us_i           (now_us),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .result_kind_o      (result_kind),
    .steps_per_second_o (rate_out),
    .is_pressed_o       (pressed_out),
    .last_o             (last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // position of an A/B level pair along the quadrature cycle
  function automatic int phase_of(logic [1:0] ab);
    case (ab)
      2'b00:   return 0;
      2'b01:   return 1;
      2'b11:   return 2;
      default: return 3;
    endcase
  endfunction

  function automatic logic [1:0] ab_at(int ph);
    case (ph % 4)
      0:       return 2'b00;
      1:       return 2'b01;
      2:       return 2'b11;
      default: return 2'b10;
    endcase
  endfunction

  function automatic int steps_for(logic [1:0] from, logic [1:0] to);
    int diff;
    diff = (phase_of(to) - phase_of(from) + 4) % 4;
    case (diff)
      1:       return -1;
      3:       return 1;
      2:       return (from[1] == from[0]) ? 2 : -2;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [31:0] rate_of(logic signed [15:0] cnt, logic [31:0] span);
    longint          c;
    longint unsigned mag;
    longint unsigned d;
    longint unsigned q;
    logic [31:0]     lo;
    c = cnt;
    mag = (c < 0) ? -c : c;
    d = span;
    if (span == 0) return (c < 0) ? 32'sh80000000 : 32'sh7fffffff;
    q = mag * USEC_PER_S / d;
    if (c < 0) begin
      if (q >= 64'h80000000) return 32'sh80000000;
      lo = q[31:0];
      return -lo;
    end
    if (q > 64'h7fffffff) return 32'sh7fffffff;
    return q[31:0];
  endfunction

  function automatic void predict_item(logic [1:0] req, logic a, logic b, logic sw,
                                       logic [31:0] now);
    int           sum;
    int           mag;
    int           n;
    logic [1:0]   ab;
    knob_result_t found[2];
    n = 0;
    case (req)
      REQ_AB: begin
        ab = {a, b};
        sample_seen = 1'b1;
        if (ab != knob_ab) begin
          sum = int'(knob_steps) + steps_for(knob_ab, ab);
          if (sum > COUNT_MAX) sum = COUNT_MAX;
          if (sum < COUNT_MIN) sum = COUNT_MIN;
          knob_steps = 16'(sum);
          knob_ab = ab;
        end
      end
      REQ_SW: begin
        sample_seen = 1'b1;
        pressed_now = !sw;
      end
      REQ_TICK: begin
        if (sample_seen) begin
          sample_seen = 1'b0;
          mag = (knob_steps < 0) ? -int'(knob_steps) : int'(knob_steps);
          if (mag > int'(rate_threshold)) begin
            found[n] = '{KIND_RATE, rate_of(knob_steps, now - last_report_us), 1'b0, 1'b0};
            n++;
            last_report_us = now;
            knob_steps = '0;
          end
          if (pressed_now != pressed_sent) begin
            found[n] = '{KIND_SWITCH, 32'sd0, pressed_now, 1'b0};
            n++;
            pressed_sent = pressed_now;
          end
          if (n > 0) found[n-1].last = 1'b1;
          for (int i = 0; i < n; i++) expected_results.push_back(found[i]);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predict_item(req_type, pin_a, pin_b, sw_level, now_us);
    if (cfg_we) rate_threshold = cfg_wdata;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d rate %0d pressed %0d last %0d",
               result_kind, rate_out, pressed_out, last_out);
        errors++;
      end else begin
        head = expected_results.pop_front();
        if (result_kind !== head.kind) begin
          $error("result_kind mismatch: expected %0d, actual %0d", head.kind, result_kind);
          errors++;
        end
        if (rate_out !== head.rate) begin
          $error("steps_per_second mismatch: expected %0d, actual %0d", head.rate, rate_out);
          errors++;
        end
        if (pressed_out !== head.pressed) begin
          $error("is_pressed mismatch: expected %0d, actual %0d", head.pressed, pressed_out);
          errors++;
        end
        if (last_out !== head.last) begin
          $error("last mismatch: expected %0d, actual %0d", head.last, last_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] req, logic a, logic b, logic sw, logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    pin_a    <= a;
    pin_b    <= b;
    sw_level <= sw;
    now_us   <= now;
    do @(posedge clk); while (in_stall);
    if (req != REQ_UNUSED) items_sent++;
  endtask

  task automatic send_ab(logic a, logic b);
    send_item(REQ_AB, a, b, 1'($urandom_range(1)), $urandom);
  endtask

  task automatic send_switch(logic sw);
    send_item(REQ_SW, 1'($urandom_range(1)), 1'($urandom_range(1)), sw, $urandom);
  endtask

  task automatic send_tick(logic [31:0] now);
    send_item(REQ_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)), now);
  endtask

  task automatic advance_knob(int step);
    cur_ab = ab_at(phase_of(cur_ab) + step);
    send_ab(cur_ab[1], cur_ab[0]);
  endtask

  task automatic send_noise();
    case ($urandom_range(2))
      0: begin
        cur_ab = 2'($urandom_range(3));
        send_ab(cur_ab[1], cur_ab[0]);
      end
      1: send_item(REQ_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), $urandom);
      default: send_tick($urandom);
    endcase
  endtask

  function automatic logic [31:0] next_tick_time();
    int p;
    p = $urandom_range(99);
    if (p < 4) ;
    else if (p < 9) now_clock = $urandom;
    else if (p < 16) now_clock += $urandom_range(16, 1);
    else now_clock += $urandom_range(200000, 17);
    return now_clock;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // a run of knob movement and noise, maybe a switch sample, then one or two ticks
  task automatic run_burst(int thr);
    int n;
    int dir;
    int p;
    n = $urandom_range(2 * thr + 8);
    dir = $urandom_range(1) ? 1 : 3;
    repeat (n) begin
      p = $urandom_range(99);
      if (p < 8) dir = 4 - dir;
      if (p < 5) send_noise();
      else if (p < 10) send_ab(cur_ab[1], cur_ab[0]);
      else advance_knob((p < 25) ? 2 : dir);
    end
    if ($urandom_range(99) < 35) send_switch(1'($urandom_range(1)));
    send_tick(next_tick_time());
    if ($urandom_range(99) < 8) send_tick(next_tick_time());
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_tick(32'd50);                         // nothing pending
    send_item(REQ_UNUSED, 1'b1, 1'b1, 1'b0, 32'hffffffff);
    send_ab(1'b0, 1'b0);                       // same level pair
    send_tick(32'hffffffff);
    send_ab(1'b1, 1'b0);
    send_ab(1'b1, 1'b1);
    send_ab(1'b0, 1'b1);
    send_ab(1'b0, 1'b0);
    send_switch(1'b0);
    send_tick(32'd0);                          // zero interval, positive, plus switch
    send_ab(1'b1, 1'b1);
    send_ab(1'b0, 1'b0);
    send_tick(32'hffffff00);
    send_ab(1'b0, 1'b1);
    send_ab(1'b1, 1'b1);
    send_ab(1'b1, 1'b0);
    send_ab(1'b0, 1'b1);
    send_switch(1'b1);
    send_tick(32'h00000100);                   // timer wrap
    send_ab(1'b1, 1'b0);
    send_switch(1'b1);
    send_tick(32'h00000300);                   // below threshold
    send_ab(1'b0, 1'b0);
    send_tick(32'h00000100);                   // zero interval, negative
    send_switch(1'b0);
    send_tick(32'd5);                          // switch only
    cur_ab = 2'b00;
    now_clock = 32'd5;
    drain_results();
  endtask

  task automatic test_large_count();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(8'd255);
    send_ab(1'b0, 1'b0);
    repeat (65) begin
      send_ab(1'b1, 1'b1);
      send_ab(1'b0, 1'b0);
    end
    now_clock += 1;
    send_tick(now_clock);
    send_ab(1'b0, 1'b1);
    repeat (65) begin
      send_ab(1'b1, 1'b0);
      send_ab(1'b0, 1'b1);
    end
    now_clock += 1;
    send_tick(now_clock);
    cur_ab = 2'b01;
    drain_results();
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int thr_lo, int thr_hi,
                                     int n_items);
    int thr;
    int start_items;
    thr = $urandom_range(thr_hi, thr_lo);
    write_threshold(8'(thr));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_items = items_sent;
    while (items_sent - start_items < n_items)
      run_burst(thr);
    drain_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(8'd0);
    hold_cycles = 400;
    repeat (20) begin
      advance_knob(1);
      if ($urandom_range(1)) send_switch(1'($urandom_range(1)));
      send_tick(next_tick_time());
    end
    drain_results();
    repeat (10) run_burst(0);
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(31, 70, 0, 5, 120);
    test_random_traffic(31, 70, 255, 255, 50);
    test_random_traffic(70, 31, 0, 0, 120);
    test_random_traffic(70, 31, 6, 40, 80);
    test_random_traffic(0, 0, 0, 255, 100);
    test_random_traffic(0, 0, 2, 2, 50);
    test_large_count();
    test_backpressure();
    drain_results();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
